/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define TBRL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tbrl assertion failed");
// check on every clock edge, reset included
`define TBRL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tbrl assertion failed");
`else
`define TBRL_ASSERT(lbl, clk, rst_n, prop)
`define TBRL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/tbrl_pkg.sv */
// ---------------------------------------------------------------------------
// tbrl_pkg
// Types and constants of the token bucket rate limiter.
// ---------------------------------------------------------------------------
package tbrl_pkg;

  localparam int RATE_W     = 20;
  localparam int TICK_W     = 10;
  localparam int AMT_W      = 32;
  localparam int TYPE_W     = 2;
  localparam int BUCKET_W   = 64;
  localparam int PROD_W     = RATE_W + TICK_W;
  localparam int BUDGET_W   = 31;
  localparam int CAP_W      = BUDGET_W + 1;

  // rate*tick*1024/1000 = p + p*3/125; the second term is a multiply by
  // 3*ceil(2^38/125) and a shift by 38, exact for every 30-bit product
  localparam int RECIP_W    = 33;
  localparam int RECIP_SH   = 38;
  localparam int FULL_W     = PROD_W + RECIP_W;
  localparam int QUOT_W     = FULL_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 33'd6597069768;

  localparam logic [BUCKET_W-1:0] BUCKET_MAX = {1'b0, {(BUCKET_W-1){1'b1}}};
  localparam logic [TICK_W-1:0]   TICK_RESET = TICK_W'(100);

  // request kinds
  localparam logic [TYPE_W-1:0] REQ_TICK    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_RESERVE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REFUND  = 2'd2;

  // configuration register indexes
  localparam logic CFG_RATE = 1'b0;
  localparam logic CFG_TICK = 1'b1;

  typedef enum logic [1:0] {
    BUD_IDLE,
    BUD_MUL,
    BUD_DIV,
    BUD_SUM
  } bud_state_t;

endpackage

/* rtl/tbrl_budget.sv */
// ---------------------------------------------------------------------------
// tbrl_budget
// Works out the refill budget rate*1024*tick_ms/1000 after each
// configuration write: one multiply, a reciprocal multiply, then an add.
// ---------------------------------------------------------------------------
module tbrl_budget (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tbrl_pkg::RATE_W-1:0]     rate,
  input  logic [tbrl_pkg::TICK_W-1:0]     tick,
  output logic [tbrl_pkg::BUDGET_W-1:0]   budget,
  output logic                            busy
);

  tbrl_pkg::bud_state_t state_r, state_nxt;
  logic [tbrl_pkg::PROD_W-1:0]     prod_r;
  logic [tbrl_pkg::QUOT_W-1:0]     quot_r;
  logic [tbrl_pkg::BUDGET_W-1:0]   budget_r;
  logic [tbrl_pkg::FULL_W-1:0]     recip_prod;
  logic                            mul_en;
  logic                            div_en;
  logic                            sum_en;

  always_comb begin
    state_nxt = state_r;
    if (start) begin
      state_nxt = tbrl_pkg::BUD_MUL;
    end else begin
      unique case (state_r)
        tbrl_pkg::BUD_IDLE: state_nxt = tbrl_pkg::BUD_IDLE;
        tbrl_pkg::BUD_MUL:  state_nxt = tbrl_pkg::BUD_DIV;
        tbrl_pkg::BUD_DIV:  state_nxt = tbrl_pkg::BUD_SUM;
        tbrl_pkg::BUD_SUM:  state_nxt = tbrl_pkg::BUD_IDLE;
        default:            state_nxt = tbrl_pkg::BUD_IDLE;
      endcase
    end
  end

  always_comb begin
    mul_en = 1'b0;
    div_en = 1'b0;
    sum_en = 1'b0;
    busy   = 1'b1;
    unique case (state_r)
      tbrl_pkg::BUD_IDLE: busy   = 1'b0;
      tbrl_pkg::BUD_MUL:  mul_en = 1'b1;
      tbrl_pkg::BUD_DIV:  div_en = 1'b1;
      tbrl_pkg::BUD_SUM:  sum_en = 1'b1;
      default:            busy   = 1'b0;
    endcase
  end

  // p*3/125 taken from the top bits of p times the scaled reciprocal
  assign recip_prod = tbrl_pkg::FULL_W'(prod_r) * tbrl_pkg::FULL_W'(tbrl_pkg::RECIP_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tbrl_pkg::BUD_IDLE;
      budget_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (sum_en) begin
        budget_r <= tbrl_pkg::BUDGET_W'(prod_r) + tbrl_pkg::BUDGET_W'(quot_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= tbrl_pkg::PROD_W'(rate) * tbrl_pkg::PROD_W'(tick);
    end
    if (div_en) begin
      quot_r <= recip_prod[tbrl_pkg::RECIP_SH +: tbrl_pkg::QUOT_W];
    end
  end

  assign budget = budget_r;

endmodule

/* rtl/token_bucket_rate_limiter.sv */
// ---------------------------------------------------------------------------
// token_bucket_rate_limiter
// Byte-budget token bucket: refill ticks, reserves and refunds.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one request per item; in_tuser is the kind (tick, reserve,
//           refund), in_tdata the byte amount.
//   out_* : exactly one item per request; out_tdata holds the bytes granted
//           (zero for ticks, refunds and unknown kinds).
//   cfg_* : register writes (index 0 rate in KiB/s, index 1 tick period in
//           ms), always ready.
// out_tvalid rises once the accepted item has passed the input register and
// then the result register; one item per cycle while out_tready is high and
// the budget unit is idle, the bucket update being one pass. Every
// configuration write restarts the budget unit: a multiply, a reciprocal
// multiply for the divide by 1000 and a final add; in_tready is low meanwhile.
// Reset: bucket empty, limited, rate 0, tick period 100 ms.
// A stalled receiver holds the result; the input register still takes one
// more item, then in_tready drops until out_tready returns.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module token_bucket_rate_limiter (
  input  logic                          clk,
  input  logic                          rst_n,
  // input requests
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tbrl_pkg::AMT_W-1:0]    in_tdata,   // [31:0] amount
  input  logic [tbrl_pkg::TYPE_W-1:0]   in_tuser,   // [1:0] req_type
  // results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tbrl_pkg::AMT_W-1:0]    out_tdata,  // [31:0] granted
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [tbrl_pkg::RATE_W-1:0]   cfg_data
);

  logic [tbrl_pkg::RATE_W-1:0]   rate_r;
  logic [tbrl_pkg::TICK_W-1:0]   tick_r;
  logic                          cfg_we;
  logic                          busy;
  logic [tbrl_pkg::BUDGET_W-1:0] budget;
  logic [tbrl_pkg::CAP_W-1:0]    cap;

  logic                          s_v_r;
  logic [tbrl_pkg::TYPE_W-1:0]   s_type_r;
  logic [tbrl_pkg::AMT_W-1:0]    s_amt_r;
  logic                          advance;
  logic                          fire;
  logic                          in_acc;

  logic [tbrl_pkg::BUCKET_W-1:0] bucket_r, bucket_nxt;
  logic                          unl_r, unl_nxt;
  logic [tbrl_pkg::AMT_W-1:0]    grant_nxt;
  logic                          out_v_r;
  logic [tbrl_pkg::AMT_W-1:0]    out_data_r;

  logic [tbrl_pkg::BUCKET_W-1:0] cur;
  logic [tbrl_pkg::BUCKET_W-1:0] tick_val;
  logic [tbrl_pkg::BUCKET_W-1:0] amt_ext;
  logic [tbrl_pkg::BUCKET_W-1:0] add_sum;
  logic                          bucket_pos;
  logic                          short_bucket;
  logic [tbrl_pkg::AMT_W-1:0]    part_grant;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
      tick_r <= tbrl_pkg::TICK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbrl_pkg::CFG_RATE: rate_r <= cfg_data;
        tbrl_pkg::CFG_TICK: tick_r <= cfg_data[tbrl_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  tbrl_budget u_budget (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_we),
    .rate   (rate_r),
    .tick   (tick_r),
    .budget (budget),
    .busy   (busy)
  );

  assign cap = {budget, 1'b0};

  // ---------------- handshake ----------------
  assign advance   = !out_v_r || out_tready;
  assign fire      = s_v_r && advance;
  assign in_tready = !busy && (!s_v_r || advance);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (in_acc) begin
      s_v_r <= 1'b1;
    end else if (fire) begin
      s_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_type_r <= in_tuser;
      s_amt_r  <= in_tdata;
    end
  end

  // ---------------- bucket update ----------------
  assign amt_ext      = {{(tbrl_pkg::BUCKET_W-tbrl_pkg::AMT_W){1'b0}}, s_amt_r};
  assign add_sum      = bucket_r + amt_ext;
  assign bucket_pos   = !bucket_r[tbrl_pkg::BUCKET_W-1] && (bucket_r != '0);
  assign short_bucket = bucket_r < amt_ext;
  assign part_grant   = short_bucket ? bucket_r[tbrl_pkg::AMT_W-1:0] : s_amt_r;

  // a negative bucket counts as empty; sum passes the cap exactly when
  // the bucket exceeds one budget, which also covers any overflow
  always_comb begin
    cur = bucket_r[tbrl_pkg::BUCKET_W-1] ? '0 : bucket_r;
    if (cur > tbrl_pkg::BUCKET_W'(budget)) begin
      tick_val = tbrl_pkg::BUCKET_W'(cap);
    end else begin
      tick_val = cur + tbrl_pkg::BUCKET_W'(budget);
    end
  end

  always_comb begin
    bucket_nxt = bucket_r;
    unl_nxt    = unl_r;
    grant_nxt  = '0;
    unique case (s_type_r)
      tbrl_pkg::REQ_TICK: begin
        if (rate_r == '0) begin
          unl_nxt    = 1'b1;
          bucket_nxt = tbrl_pkg::BUCKET_MAX;
        end else begin
          unl_nxt    = 1'b0;
          bucket_nxt = tick_val;
        end
      end
      tbrl_pkg::REQ_RESERVE: begin
        if (unl_r) begin
          grant_nxt = s_amt_r;
        end else if (bucket_pos) begin
          grant_nxt  = part_grant;
          bucket_nxt = bucket_r - {{(tbrl_pkg::BUCKET_W-tbrl_pkg::AMT_W){1'b0}}, part_grant};
        end
      end
      tbrl_pkg::REQ_REFUND: begin
        if ((s_amt_r != '0) && !unl_r) begin
          // saturate where a non-negative bucket wraps into the sign bit
          if (!bucket_r[tbrl_pkg::BUCKET_W-1] && add_sum[tbrl_pkg::BUCKET_W-1]) begin
            bucket_nxt = tbrl_pkg::BUCKET_MAX;
          end else begin
            bucket_nxt = add_sum;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_r <= '0;
      unl_r    <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (fire) begin
        bucket_r <= bucket_nxt;
        unl_r    <= unl_nxt;
        out_v_r  <= 1'b1;
      end else if (out_tready) begin
        out_v_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= grant_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  `TBRL_ASSERT(a_unl_full, clk, rst_n, unl_r |-> (bucket_r == tbrl_pkg::BUCKET_MAX))
  `TBRL_ASSERT(a_cfg_busy, clk, rst_n, cfg_we |=> busy)
  `TBRL_ASSERT_ALWAYS(a_ready_idle, clk, in_tready |-> !busy)
  `TBRL_ASSERT(a_tick_cap, clk, rst_n,
    (fire && (s_type_r == tbrl_pkg::REQ_TICK) && (rate_r != '0)) |=>
      (!unl_r && !bucket_r[tbrl_pkg::BUCKET_W-1] &&
       (bucket_r <= tbrl_pkg::BUCKET_W'(cap))))

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the token bucket rate limiter. A directed run
// covers unlimited mode, saturation after leaving it, empty-bucket reserves,
// zero tick periods, unknown request kinds and the register extremes. Random
// phases then reprogram the rate and the tick period and send mixed ticks,
// reserves and refunds. Every accepted request is run through a local model
// of the bucket, and each result is checked against the expected grant.
// ---------------------------------------------------------------------------
module tb_top;

  localparam logic [tbrl_pkg::TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [tbrl_pkg::TYPE_W-1:0] kind;
    logic [tbrl_pkg::AMT_W-1:0]  amount;
  } req_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [tbrl_pkg::AMT_W-1:0]    in_tdata   = '0;
  logic [tbrl_pkg::TYPE_W-1:0]   in_tuser   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [tbrl_pkg::AMT_W-1:0]    out_tdata;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_index  = 1'b0;
  logic [tbrl_pkg::RATE_W-1:0]   cfg_data   = '0;

  // bucket model, mirrors the reset state of the block
  logic [tbrl_pkg::RATE_W-1:0]   rate_kibps   = '0;
  logic [tbrl_pkg::TICK_W-1:0]   tick_ms      = tbrl_pkg::TICK_RESET;
  longint                        bucket_now   = 0;
  bit                            unlimited_now = 1'b0;

  req_t                          pending_reqs[$];
  logic [tbrl_pkg::AMT_W-1:0]    granted_q[$];
  int                            mismatches = 0;
  bit                            steady     = 1'b0;

  always #2 clk = ~clk;

  token_bucket_rate_limiter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic longint add_capped(input longint base, input longint add);
    if (base > longint'(tbrl_pkg::BUCKET_MAX) - add) return longint'(tbrl_pkg::BUCKET_MAX);
    return base + add;
  endfunction

  // advance the bucket by one request and return the bytes granted
  function automatic logic [tbrl_pkg::AMT_W-1:0] settle_request(input req_t r);
    longint                     budget;
    longint                     cur;
    longint                     cap;
    logic [tbrl_pkg::AMT_W-1:0] g;
    g = '0;
    case (r.kind)
      tbrl_pkg::REQ_TICK: begin
        if (rate_kibps == '0) begin
          unlimited_now = 1'b1;
          bucket_now    = longint'(tbrl_pkg::BUCKET_MAX);
        end else begin
          budget = longint'({44'b0, rate_kibps}) * 1024 * longint'({54'b0, tick_ms}) / 1000;
          unlimited_now = 1'b0;
          cur = (bucket_now < 0) ? 0 : bucket_now;
          cur = add_capped(cur, budget);
          cap = budget * 2;
          if (cur > cap) cur = cap;
          bucket_now = cur;
        end
      end
      tbrl_pkg::REQ_RESERVE: begin
        if (unlimited_now) begin
          g = r.amount;
        end else if (bucket_now > 0) begin
          if (bucket_now < longint'({32'b0, r.amount})) g = bucket_now[31:0];
          else g = r.amount;
          bucket_now = bucket_now - longint'({32'b0, g});
        end
      end
      tbrl_pkg::REQ_REFUND: begin
        if (r.amount != '0 && !unlimited_now)
          bucket_now = add_capped(bucket_now, longint'({32'b0, r.amount}));
      end
      default: ;
    endcase
    return g;
  endfunction

  // request driver
  always @(posedge clk) begin : drive_proc
    req_t acc;
    req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        acc.kind   = in_tuser;
        acc.amount = in_tdata;
        granted_q.push_back(settle_request(acc));
      end
      // hold the item until it is taken
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 23)) begin
          nxt = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.kind;
          in_tdata  <= nxt.amount;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_proc
    logic [tbrl_pkg::AMT_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (granted_q.size() == 0) begin
          $display("%0t: unexpected result, granted %0d", $time, out_tdata);
          mismatches++;
        end else begin
          want = granted_q.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: granted mismatch, expected %0d actual %0d",
                     $time, want, out_tdata);
            mismatches++;
          end
        end
      end
      out_tready <= steady || $urandom_range(0, 99) >= 23;
    end
  end

  task automatic push_req(input logic [tbrl_pkg::TYPE_W-1:0] kind,
                          input logic [tbrl_pkg::AMT_W-1:0] amount);
    req_t r;
    r.kind   = kind;
    r.amount = amount;
    pending_reqs.push_back(r);
  endtask

  // wait until every queued item has gone through and come back
  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || granted_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic program_regs(input bit set_rate, input logic [tbrl_pkg::RATE_W-1:0] rate,
                              input bit set_tick, input logic [tbrl_pkg::TICK_W-1:0] period);
    if (set_rate) begin
      cfg_index <= tbrl_pkg::CFG_RATE;
      cfg_data  <= rate;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      rate_kibps = rate;
    end
    if (set_tick) begin
      cfg_index <= tbrl_pkg::CFG_TICK;
      cfg_data  <= {{(tbrl_pkg::RATE_W-tbrl_pkg::TICK_W){1'b0}}, period};
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      tick_ms = period;
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stim_proc
    logic [tbrl_pkg::RATE_W-1:0] rate;
    logic [tbrl_pkg::TICK_W-1:0] period;
    logic [tbrl_pkg::AMT_W-1:0]  amt;
    logic [tbrl_pkg::TYPE_W-1:0] kind;
    int                          sel;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: limited with an empty bucket until the first tick
    push_req(tbrl_pkg::REQ_RESERVE, 32'd5);
    push_req(tbrl_pkg::REQ_TICK, '1);
    push_req(tbrl_pkg::REQ_RESERVE, '1);
    push_req(tbrl_pkg::REQ_RESERVE, '0);
    push_req(tbrl_pkg::REQ_REFUND, 32'd7);
    push_req(tbrl_pkg::REQ_REFUND, '0);
    push_req(REQ_UNKNOWN, '1);
    drain();

    // still unlimited until the next tick, which then saturates and caps
    program_regs(1'b1, 20'd1, 1'b0, '0);
    push_req(tbrl_pkg::REQ_RESERVE, 32'd9);
    push_req(tbrl_pkg::REQ_TICK, '0);
    push_req(tbrl_pkg::REQ_RESERVE, '1);
    push_req(tbrl_pkg::REQ_RESERVE, 32'd3);
    push_req(tbrl_pkg::REQ_REFUND, '1);
    push_req(tbrl_pkg::REQ_RESERVE, 32'h1000);
    push_req(tbrl_pkg::REQ_REFUND, '0);
    push_req(tbrl_pkg::REQ_TICK, 32'h5a5a_a5a5);
    drain();

    // zero tick period gives a zero budget
    program_regs(1'b0, '0, 1'b1, '0);
    push_req(tbrl_pkg::REQ_TICK, '0);
    push_req(tbrl_pkg::REQ_RESERVE, 32'd1);
    drain();

    program_regs(1'b1, '1, 1'b1, '1);
    push_req(tbrl_pkg::REQ_TICK, '0);
    push_req(tbrl_pkg::REQ_RESERVE, '1);
    push_req(tbrl_pkg::REQ_TICK, '0);
    push_req(tbrl_pkg::REQ_TICK, '0);
    push_req(tbrl_pkg::REQ_RESERVE, 32'h8000_0000);
    push_req(REQ_UNKNOWN, '0);
    drain();

    program_regs(1'b1, 20'd1000000, 1'b1, 10'd1000);
    push_req(tbrl_pkg::REQ_TICK, '0);
    push_req(tbrl_pkg::REQ_RESERVE, '1);
    drain();

    // random phases
    for (int ph = 0; ph < 13; ph++) begin
      steady = (ph >= 5 && ph <= 7);
      case ($urandom_range(0, 7))
        0:       rate = '0;
        1:       rate = '1;
        2:       rate = 20'd1;
        3, 4:    rate = tbrl_pkg::RATE_W'($urandom_range(1, 100));
        default: rate = tbrl_pkg::RATE_W'($urandom_range(1, 1000000));
      endcase
      case ($urandom_range(0, 7))
        0:       period = '0;
        1:       period = '1;
        2:       period = 10'd1;
        default: period = tbrl_pkg::TICK_W'($urandom_range(1, 1000));
      endcase
      sel = $urandom_range(0, 3);
      program_regs(sel != 1, rate, sel != 0, period);
      if ($urandom_range(0, 3) != 0) push_req(tbrl_pkg::REQ_TICK, $urandom);
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 9))
          0:       amt = '0;
          1:       amt = '1;
          2, 3:    amt = $urandom;
          default: amt = $urandom >> $urandom_range(8, 31);
        endcase
        sel = $urandom_range(0, 19);
        if (sel < 4)       kind = tbrl_pkg::REQ_TICK;
        else if (sel < 13) kind = tbrl_pkg::REQ_RESERVE;
        else if (sel < 19) kind = tbrl_pkg::REQ_REFUND;
        else               kind = REQ_UNKNOWN;
        push_req(kind, amt);
      end
      drain();
    end

    steady = 1'b0;
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("token_bucket_rate_limiter regression: pass");
    end else begin
      $display("token_bucket_rate_limiter regression: fail");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #400000;
    $display("token_bucket_rate_limiter regression: fail");
    $finish;
  end

endmodule
